### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rscf_pkg.sv
// ---------------------------------------------------------------------------
// rscf_pkg
// Shared constants, types and the folded byte add of the row signer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rscf_pkg;

    localparam int MAX_ROWS = 64;
    localparam int IDX_W    = $clog2(MAX_ROWS);
    localparam int ROW_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int SIG_W    = 16;
    localparam int ROWS_W   = 7;

    localparam logic [BYTE_W-1:0] SUM_INIT = 8'hFF;

    typedef logic [IDX_W-1:0] t_idx;

    // Signed row leaving the accumulator toward the signature store.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [SIG_W-1:0] sig;
        logic             bad;
        t_idx             idx;
    } t_sig_item;

    // Decision leaving the store.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             changed;
        logic [SIG_W-1:0] sig;
        logic             bad;
    } t_result;

    // 8-bit add with end-around carry.
    function automatic logic [BYTE_W-1:0] fold_add(input logic [BYTE_W-1:0] x,
                                                   input logic [BYTE_W-1:0] y);
        logic [BYTE_W:0] t;
        t = {1'b0, x} + {1'b0, y};
        return t[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, t[BYTE_W]};
    endfunction

endpackage

### src/rscf_in_if.sv
// ---------------------------------------------------------------------------
// rscf_in_if
// Byte channel: one row byte with row number, last mark and given key.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rscf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  row_number;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] given_key;

    modport source (output valid, row_number, data_byte, last_byte, given_key,
                    input ready);
    modport sink   (input valid, row_number, data_byte, last_byte, given_key,
                    output ready);
endinterface

### src/rscf_out_if.sv
// ---------------------------------------------------------------------------
// rscf_out_if
// Decision channel: one per finished row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rscf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_row;
    logic        row_changed;
    logic [15:0] row_signature;
    logic        row_out_of_range;

    modport source (output valid, out_row, row_changed, row_signature, row_out_of_range,
                    input ready);
    modport sink   (input valid, out_row, row_changed, row_signature, row_out_of_range,
                    output ready);
endinterface

### src/rscf_cfg_if.sv
// ---------------------------------------------------------------------------
// rscf_cfg_if
// Configuration write channel for the display row count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rscf_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/rscf_sum.sv
// ---------------------------------------------------------------------------
// rscf_sum
// Running Fletcher sums and the final signature and range check of a row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rscf_sum (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [rscf_pkg::ROW_W-1:0]       i_row_number,
    input  logic [rscf_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                             i_last_byte,
    input  logic [rscf_pkg::SIG_W-1:0]       i_given_key,
    input  logic [rscf_pkg::ROWS_W-1:0]      i_display_rows,
    output rscf_pkg::t_sig_item              o_item
);
    import rscf_pkg::*;

    logic [BYTE_W-1:0] r_lo, r_hi;
    logic [BYTE_W-1:0] n_lo, n_hi;
    logic [SIG_W-1:0]  sig_sel;

    always_comb begin
        n_lo    = fold_add(r_lo, i_data_byte);
        n_hi    = fold_add(r_hi, n_lo);
        sig_sel = (i_given_key != '0) ? i_given_key : {n_hi, n_lo};
        o_item.row = i_row_number;
        o_item.sig = (sig_sel == '0) ? SIG_W'(1) : sig_sel;
        o_item.bad = (i_row_number == '0)
                  || ({1'b0, i_row_number} > {2'b00, i_display_rows})
                  || ({1'b0, i_row_number} > (ROW_W+1)'(MAX_ROWS));
        o_item.idx = IDX_W'(i_row_number - ROW_W'(1));
    end

    // Reload both sums after the last byte of a row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= SUM_INIT;
            r_hi <= SUM_INIT;
        end else if (i_accept) begin
            r_lo <= i_last_byte ? SUM_INIT : n_lo;
            r_hi <= i_last_byte ? SUM_INIT : n_hi;
        end
    end

endmodule

### src/rscf_store.sv
// ---------------------------------------------------------------------------
// rscf_store
// Signature memory with compare, write-back, forwarding and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rscf_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  rscf_pkg::t_sig_item  i_item,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_valid,
    output rscf_pkg::t_result    o_result
);
    import rscf_pkg::*;

    logic [SIG_W-1:0]    r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_vld;
    logic [SIG_W-1:0]    r_rd_data;
    logic                r_rd_vld;

    logic                r_s1_valid;
    t_sig_item           r_s1;
    logic                r_wr_valid;
    t_idx                r_wr_idx;
    logic [SIG_W-1:0]    r_wr_data;
    logic                r_o_valid;
    t_result             r_out;

    logic [SIG_W-1:0]    old_sig;
    logic                fwd_hit;
    logic                changed;
    logic                s1_adv;
    logic                wr_en;

    always_comb begin
        fwd_hit    = r_wr_valid && (r_wr_idx == r_s1.idx);
        old_sig    = fwd_hit ? r_wr_data : (r_rd_vld ? r_rd_data : '0);
        changed    = !r_s1.bad && (old_sig != r_s1.sig);
        s1_adv     = r_s1_valid && (!r_o_valid || i_out_ready);
        wr_en      = s1_adv && changed;
        o_in_ready = !r_s1_valid || s1_adv;
    end

    // Memory read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rd_data <= r_mem[i_item.idx];
            r_rd_vld  <= r_vld[i_item.idx];
            r_s1      <= i_item;
        end
    end

    // Memory write port and output register.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1.idx] <= r_s1.sig;
            r_wr_idx        <= r_s1.idx;
            r_wr_data       <= r_s1.sig;
        end
        if (s1_adv) begin
            r_out.row     <= r_s1.row;
            r_out.changed <= changed;
            r_out.sig     <= r_s1.sig;
            r_out.bad     <= r_s1.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_s1.idx] <= 1'b1;
                r_wr_valid      <= 1'b1;
            end
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_out;

endmodule

### src/row_signature_change_filter.sv
// ---------------------------------------------------------------------------
// row_signature_change_filter
// Signs display rows with a folded Fletcher-16 and reports changed rows.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained while the decision side takes items.
// Decision path: a last byte goes through the memory read register, then the
//   compare into the output register.
// Memory port: one read per last byte, one write per changed row, no conflicts.
// Reset: sums reload to 0xFF, every row reads as never painted, display_rows 24.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module row_signature_change_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rscf_in_if.sink    i_row,
    rscf_cfg_if.sink   i_cfg,
    rscf_out_if.source o_dec
);
    import rscf_pkg::*;

    logic [ROWS_W-1:0] r_display_rows;
    logic              in_ready;
    logic              accept;
    logic              load;
    t_sig_item         sig_item;
    logic              dec_valid;
    t_result           dec;

    // An item is taken whenever the compare stage is free or moving on.
    assign accept      = i_row.valid && in_ready;
    // Only the last byte of a row touches the signature memory.
    assign load        = accept && i_row.last_byte;
    assign i_row.ready = in_ready;

    // Configuration: always ready; to be written only while idle, which the block does not enforce.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_rows <= ROWS_W'(24);
        end else if (i_cfg.valid) begin
            r_display_rows <= i_cfg.data;
        end
    end

    // Fold each byte into the running sums; form the signature and range check on the last byte.
    rscf_sum u_sum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_row_number   (i_row.row_number),
        .i_data_byte    (i_row.data_byte),
        .i_last_byte    (i_row.last_byte),
        .i_given_key    (i_row.given_key),
        .i_display_rows (r_display_rows),
        .o_item         (sig_item)
    );

    // Read the stored signature, compare, write back on change, hold the decision.
    rscf_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_item      (sig_item),
        .i_out_ready (o_dec.ready),
        .o_in_ready  (in_ready),
        .o_valid     (dec_valid),
        .o_result    (dec)
    );

    assign o_dec.valid            = dec_valid;
    assign o_dec.out_row          = dec.row;
    assign o_dec.row_changed      = dec.changed;
    assign o_dec.row_signature    = dec.sig;
    assign o_dec.row_out_of_range = dec.bad;

    // A signature is never zero.
    `ASSERT_IMPLIES(a_sig_nonzero, i_clk, i_rst_n, dec_valid, dec.sig != '0, "zero signature")
    // Out-of-range rows never count as changed.
    `ASSERT_IMPLIES(a_bad_unchanged, i_clk, i_rst_n, dec_valid && dec.bad, !dec.changed,
        "out-of-range row reported as changed")
    // Input stalls only under output backpressure.
    `ASSERT_IMPLIES(a_stall_cause, i_clk, i_rst_n, !in_ready, dec_valid && !o_dec.ready,
        "input stalled without output backpressure")
    // A last byte accepted under output backpressure leaves a decision pending next cycle.
    `ASSERT_NEXT(a_load_yields, i_clk, i_rst_n, load && dec_valid && !o_dec.ready, dec_valid,
        "decision dropped under backpressure")

endmodule
